>>> rtl/core/adcs_pkg.sv
// Package for the ADC two-channel averaging sequencer: word types, CSR indexes,
// reset values and sequencer state codes.
// No dependencies; the sequencer core in rtl/core refers to it by scoped names.
`default_nettype none

package adcs_pkg;

   // Configuration register indexes (the index field is wider than the list).
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIVIDER        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_AVERAGE = 2'd1;

   // Register widths and reset values.
   localparam int unsigned DIV_W = 8;
   localparam int unsigned SPA_W = 7;
   localparam logic [DIV_W-1:0] TICK_DIVIDER_RESET = 8'd10;
   localparam logic [SPA_W-1:0] SAMPLES_RESET      = 7'd8;
   localparam logic [SPA_W-1:0] MAX_SAMPLES        = 7'd64;

   // Field widths of the words.
   localparam int unsigned FIELD_W = 10;

   typedef struct packed {
      logic               req_type;
      logic [FIELD_W-1:0] adc_sample;
   } adcs_req_type;

   typedef struct packed {
      logic               start_conversion;
      logic               conversion_channel;
      logic [FIELD_W-1:0] pot_average;
      logic               pot_done;
      logic [FIELD_W-1:0] battery_average;
      logic               battery_done;
   } adcs_rsp_type;

   // Event codes carried in req_type.
   localparam logic EVT_TICK       = 1'b0;
   localparam logic EVT_CONVERSION = 1'b1;

   // Channel codes.
   localparam logic CHAN_POT     = 1'b0;
   localparam logic CHAN_BATTERY = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } adcs_state_type;

   // What the divider result is used for.
   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_TICK,
      JOB_POT_AVG,
      JOB_BAT_AVG
   } adcs_job_type;

endpackage

`default_nettype wire

>>> rtl/core/adcs_div.sv
// Shared restoring divider, one quotient bit per clock.
// Used by the sequencer core for both the prescaler modulo and the block averages.
// No package dependencies.
`default_nettype none

module adcs_div #(
   parameter int unsigned DIVIDEND_W = 16,
   parameter int unsigned DIVISOR_W  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One restoring step: bring in the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // Step sequencing: load on start, count down, pulse done after the last bit.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/core/adc_two_channel_averaging_sequencer_core.sv
// Top level of the ADC two-channel averaging sequencer.
// Depends on adcs_pkg (word types, codes) and adcs_div (shared divider).
//
//   Channel | Direction | Handshake            | Word
//   req     | in        | req_valid, req_stall | adcs_pkg::adcs_req_type
//   rsp     | out       | rsp_valid, rsp_stall | adcs_pkg::adcs_rsp_type
//   csr     | in        | csr_valid, csr_ready | csr_index, csr_data
//
// A timer tick passes through ST_IDLE, ST_DIVIDE and ST_FINISH before its result is
// registered: the shared divider works out the prescaler modulo one bit a cycle over
// SAMPLE_BITS+6 steps. A conversion that closes a block takes the same path to form its
// average; any other conversion goes from ST_IDLE straight to ST_FINISH. The next word is
// taken only once the sequencer is back in ST_IDLE.
// Reset is synchronous and restores the register defaults and all sums and counts.
// A result word waiting on rsp_stall does not hold up acceptance of the next word;
// a finished word waits in the sequencer only while the output register is full and stalled.
`default_nettype none

module adc_two_channel_averaging_sequencer_core #(
   parameter int unsigned SAMPLE_BITS = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire adcs_pkg::adcs_req_type        req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output adcs_pkg::adcs_rsp_type             rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [adcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [adcs_pkg::DIV_W-1:0]    csr_data
);

   localparam int unsigned SUM_W = SAMPLE_BITS + 6;
   localparam logic [SUM_W-1:0] SAMPLE_MASK = SUM_W'((1 << SAMPLE_BITS) - 1);

   // Configuration registers.
   logic [adcs_pkg::DIV_W-1:0] tick_divider_ff;
   logic [adcs_pkg::SPA_W-1:0] samples_ff;

   // Channel state.
   logic [adcs_pkg::DIV_W-1:0] tick_count_ff, tick_count_in;
   logic                       ptr_pot_ff, ptr_pot_in;
   logic [SUM_W-1:0]           pot_sum_ff, pot_sum_in;
   logic [adcs_pkg::SPA_W-1:0] pot_count_ff, pot_count_in;
   logic [SUM_W-1:0]           bat_sum_ff, bat_sum_in;
   logic [adcs_pkg::SPA_W-1:0] bat_count_ff, bat_count_in;
   logic [SAMPLE_BITS-1:0]     pot_avg_ff, pot_avg_in;
   logic [SAMPLE_BITS-1:0]     bat_avg_ff, bat_avg_in;

   // Sequencer.
   adcs_pkg::adcs_state_type state_ff, state_in;
   adcs_pkg::adcs_job_type   job_ff, job_in;
   logic start_ff, start_in;
   logic pdone_ff, pdone_in;
   logic bdone_ff, bdone_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   adcs_pkg::adcs_rsp_type rsp_ff, rsp_in;

   // Divider interface.
   logic                       div_start;
   logic [SUM_W-1:0]           div_dividend;
   logic [adcs_pkg::DIV_W-1:0] div_divisor;
   logic                       div_done;
   logic [SUM_W-1:0]           div_quotient;
   logic [adcs_pkg::DIV_W-1:0] div_remainder;

   // Working values.
   logic                       accept;
   logic [adcs_pkg::DIV_W-1:0] div_eff;
   logic [adcs_pkg::SPA_W-1:0] block_n;
   logic [SUM_W-1:0]           sample;
   logic [SUM_W-1:0]           pot_sum_next;
   logic [SUM_W-1:0]           bat_sum_next;
   logic [adcs_pkg::SPA_W-1:0] pot_count_next;
   logic [adcs_pkg::SPA_W-1:0] bat_count_next;
   logic [SUM_W-1:0]           pot_avg_ext;
   logic [SUM_W-1:0]           bat_avg_ext;
   logic                       out_free;

   adcs_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (adcs_pkg::DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != adcs_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Effective divider and block length after clamping, the masked sample and the next sums and counts.
   always_comb begin
      div_eff = (tick_divider_ff == '0) ? adcs_pkg::DIV_W'(1) : tick_divider_ff;
      if (samples_ff == '0) begin
         block_n = adcs_pkg::SPA_W'(1);
      end else if (samples_ff > adcs_pkg::MAX_SAMPLES) begin
         block_n = adcs_pkg::MAX_SAMPLES;
      end else begin
         block_n = samples_ff;
      end
      sample         = SUM_W'(req_data.adc_sample) & SAMPLE_MASK;
      pot_sum_next   = pot_sum_ff + sample;
      bat_sum_next   = bat_sum_ff + sample;
      pot_count_next = pot_count_ff + 1'b1;
      bat_count_next = bat_count_ff + 1'b1;
      pot_avg_ext    = SUM_W'(pot_avg_ff);
      bat_avg_ext    = SUM_W'(bat_avg_ff);
   end

   // Sequencer: next state, state updates and divider requests.
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      start_in      = start_ff;
      pdone_in      = pdone_ff;
      bdone_in      = bdone_ff;
      tick_count_in = tick_count_ff;
      ptr_pot_in    = ptr_pot_ff;
      pot_sum_in    = pot_sum_ff;
      pot_count_in  = pot_count_ff;
      bat_sum_in    = bat_sum_ff;
      bat_count_in  = bat_count_ff;
      pot_avg_in    = pot_avg_ff;
      bat_avg_in    = bat_avg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      div_start     = 1'b0;
      div_dividend  = SUM_W'(tick_count_ff) + 1'b1;
      div_divisor   = div_eff;

      unique case (state_ff)
         adcs_pkg::ST_IDLE: begin
            if (accept) begin
               start_in = 1'b0;
               pdone_in = 1'b0;
               bdone_in = 1'b0;
               if (req_data.req_type == adcs_pkg::EVT_TICK) begin
                  // Prescaler modulo goes through the divider.
                  div_start = 1'b1;
                  job_in    = adcs_pkg::JOB_TICK;
                  state_in  = adcs_pkg::ST_DIVIDE;
               end else if (ptr_pot_ff) begin
                  // Potentiometer conversion; a full block is averaged.
                  if (pot_count_next >= block_n) begin
                     div_start    = 1'b1;
                     div_dividend = pot_sum_next;
                     div_divisor  = adcs_pkg::DIV_W'(block_n);
                     pot_sum_in   = '0;
                     pot_count_in = '0;
                     ptr_pot_in   = 1'b0;
                     job_in       = adcs_pkg::JOB_POT_AVG;
                     state_in     = adcs_pkg::ST_DIVIDE;
                  end else begin
                     pot_sum_in   = pot_sum_next;
                     pot_count_in = pot_count_next;
                     job_in       = adcs_pkg::JOB_NONE;
                     state_in     = adcs_pkg::ST_FINISH;
                  end
               end else begin
                  // Battery conversion always hands back to the potentiometer.
                  ptr_pot_in = 1'b1;
                  if (bat_count_next >= block_n) begin
                     div_start    = 1'b1;
                     div_dividend = bat_sum_next;
                     div_divisor  = adcs_pkg::DIV_W'(block_n);
                     bat_sum_in   = '0;
                     bat_count_in = '0;
                     job_in       = adcs_pkg::JOB_BAT_AVG;
                     state_in     = adcs_pkg::ST_DIVIDE;
                  end else begin
                     bat_sum_in   = bat_sum_next;
                     bat_count_in = bat_count_next;
                     job_in       = adcs_pkg::JOB_NONE;
                     state_in     = adcs_pkg::ST_FINISH;
                  end
               end
            end
         end
         adcs_pkg::ST_DIVIDE: begin
            if (div_done) begin
               unique case (job_ff)
                  adcs_pkg::JOB_TICK: begin
                     tick_count_in = div_remainder;
                     start_in      = (div_remainder == '0);
                  end
                  adcs_pkg::JOB_POT_AVG: begin
                     pot_avg_in = div_quotient[SAMPLE_BITS-1:0];
                     pdone_in   = 1'b1;
                  end
                  adcs_pkg::JOB_BAT_AVG: begin
                     bat_avg_in = div_quotient[SAMPLE_BITS-1:0];
                     bdone_in   = 1'b1;
                  end
                  default: begin
                  end
               endcase
               state_in = adcs_pkg::ST_FINISH;
            end
         end
         adcs_pkg::ST_FINISH: begin
            // Load the output register once it is free.
            if (out_free) begin
               rsp_in.start_conversion   = start_ff;
               rsp_in.conversion_channel = ptr_pot_ff ? adcs_pkg::CHAN_POT
                                                      : adcs_pkg::CHAN_BATTERY;
               rsp_in.pot_average        = pot_avg_ext[adcs_pkg::FIELD_W-1:0];
               rsp_in.pot_done           = pdone_ff;
               rsp_in.battery_average    = bat_avg_ext[adcs_pkg::FIELD_W-1:0];
               rsp_in.battery_done       = bdone_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = adcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adcs_pkg::ST_IDLE;
         end
      endcase
   end

   // State register of the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divider_ff <= adcs_pkg::TICK_DIVIDER_RESET;
         samples_ff      <= adcs_pkg::SAMPLES_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            adcs_pkg::CSR_TICK_DIVIDER:        tick_divider_ff <= csr_data;
            adcs_pkg::CSR_SAMPLES_PER_AVERAGE: samples_ff <= csr_data[adcs_pkg::SPA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Channel state, job flags and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         ptr_pot_ff    <= 1'b1;
         pot_sum_ff    <= '0;
         pot_count_ff  <= '0;
         bat_sum_ff    <= '0;
         bat_count_ff  <= '0;
         pot_avg_ff    <= '0;
         bat_avg_ff    <= '0;
         job_ff        <= adcs_pkg::JOB_NONE;
         start_ff      <= 1'b0;
         pdone_ff      <= 1'b0;
         bdone_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         ptr_pot_ff    <= ptr_pot_in;
         pot_sum_ff    <= pot_sum_in;
         pot_count_ff  <= pot_count_in;
         bat_sum_ff    <= bat_sum_in;
         bat_count_ff  <= bat_count_in;
         pot_avg_ff    <= pot_avg_in;
         bat_avg_ff    <= bat_avg_in;
         job_ff        <= job_in;
         start_ff      <= start_in;
         pdone_ff      <= pdone_in;
         bdone_ff      <= bdone_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
